// ===== rtl/ps2mct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_pkg
// Shared types and constants for the PS/2 mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package ps2mct_pkg;

  localparam int COORD_WIDTH_DEF = 12;
  localparam int REG_W           = 12;
  localparam int BYTE_W          = 8;
  localparam int MOVE_X_W        = 9;
  localparam int MOVE_Y_W        = 10;
  localparam int CFG_ADDR_W      = 4;
  localparam int CFG_DATA_W      = 32;

  localparam logic [REG_W-1:0] H_RES_RST  = 12'd1024;
  localparam logic [REG_W-1:0] V_RES_RST  = 12'd768;
  localparam logic [REG_W-1:0] MARGIN_RST = 12'd0;
  localparam int               POS_X_RST  = 512;
  localparam int               POS_Y_RST  = 384;

  // header byte bits
  localparam int HDR_LEFT   = 0;
  localparam int HDR_RIGHT  = 1;
  localparam int HDR_SYNC   = 3;
  localparam int HDR_X_SIGN = 4;
  localparam int HDR_Y_SIGN = 5;
  localparam int HDR_X_OVF  = 6;
  localparam int HDR_Y_OVF  = 7;

  typedef enum logic [1:0] {
    REG_H_RES  = 2'd0,
    REG_V_RES  = 2'd1,
    REG_MARGIN = 2'd2,
    REG_NONE   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_WAIT_HDR = 3'b001,
    ST_GOT_HDR  = 3'b010,
    ST_GOT_X    = 3'b100
  } byte_pos_t;

  function automatic int out_data_w(input int cw);
    return ((2 * cw + 2 + MOVE_X_W + MOVE_Y_W + 7) / 8) * 8;
  endfunction

endpackage

// ===== rtl/ps2mct_axis_clamp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_axis_clamp
// Moves one cursor axis by a signed delta and clamps it to
// [0, resolution - margin], the limit saturated to the coordinate range.
// ----------------------------------------------------------------------------
module ps2mct_axis_clamp #(
  parameter int CW = ps2mct_pkg::COORD_WIDTH_DEF
) (
  input  logic [CW-1:0]                          pos,
  input  logic signed [ps2mct_pkg::MOVE_Y_W-1:0] delta,
  input  logic [ps2mct_pkg::REG_W-1:0]           res,
  input  logic [ps2mct_pkg::REG_W-1:0]           margin,
  output logic [CW-1:0]                          pos_new
);
  import ps2mct_pkg::*;

  localparam int SW = ((CW > REG_W) ? CW : REG_W) + 2;

  logic signed [SW-1:0] limit_raw;
  logic signed [SW-1:0] limit;
  logic signed [SW-1:0] target;
  logic signed [SW-1:0] max_coord;

  always_comb begin
    max_coord = $signed({{(SW-CW){1'b0}}, {CW{1'b1}}});
    limit_raw = $signed({{(SW-REG_W){1'b0}}, res}) - $signed({{(SW-REG_W){1'b0}}, margin});
    if (limit_raw < 0) begin
      limit = '0;
    end else if (limit_raw > max_coord) begin
      limit = max_coord;
    end else begin
      limit = limit_raw;
    end
    target = $signed({{(SW-CW){1'b0}}, pos}) + $signed({{(SW-MOVE_Y_W){delta[MOVE_Y_W-1]}}, delta});
    if (target >= limit) begin
      pos_new = limit[CW-1:0];
    end else if (target < 0) begin
      pos_new = '0;
    end else begin
      pos_new = target[CW-1:0];
    end
  end

endmodule

// ===== rtl/ps2_mouse_packet_cursor_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker
// Frames PS/2 mouse bytes into three-byte packets, tracks buttons and moves
// a clamped cursor, one result per completed packet.
// A byte taken sits in the input register; its result is loaded into the
// output register when the output side can advance.
// Throughput: one byte per cycle while the output side is ready.
// Reset: synchronous active-low rst_n; framing idle, cursor at 512/384,
// buttons released, registers 1024/768/0, no result pending.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_WIDTH = ps2mct_pkg::COORD_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input stream
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [ps2mct_pkg::BYTE_W-1:0]        in_tdata,   // rx_byte
  input  logic                                 in_tuser,   // rx_error
  // result stream
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // cursor_x, cursor_y, left_pressed, right_pressed, move_x, move_y, zero pad
  output logic [ps2mct_pkg::out_data_w(COORD_WIDTH)-1:0] out_tdata,
  output logic                                 out_tuser,  // packet_dropped
  // configuration
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [ps2mct_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ps2mct_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ps2mct_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                 cfg_pready
);
  import ps2mct_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int OUT_W  = out_data_w(COORD_WIDTH);
  localparam int USED_W = 2 * CW + 2 + MOVE_X_W + MOVE_Y_W;
  localparam logic [CW-1:0] POS_X_INIT = CW'(POS_X_RST);
  localparam logic [CW-1:0] POS_Y_INIT = CW'(POS_Y_RST);

  // configuration registers
  logic [REG_W-1:0] h_res_r, v_res_r, margin_r;
  reg_idx_t         cfg_idx;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_res_r  <= H_RES_RST;
      v_res_r  <= V_RES_RST;
      margin_r <= MARGIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_H_RES:  h_res_r  <= cfg_pwdata[REG_W-1:0];
        REG_V_RES:  v_res_r  <= cfg_pwdata[REG_W-1:0];
        REG_MARGIN: margin_r <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_H_RES:  cfg_prdata = {{(CFG_DATA_W-REG_W){1'b0}}, h_res_r};
      REG_V_RES:  cfg_prdata = {{(CFG_DATA_W-REG_W){1'b0}}, v_res_r};
      REG_MARGIN: cfg_prdata = {{(CFG_DATA_W-REG_W){1'b0}}, margin_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // input register
  logic              in_v_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_err_r;
  logic              advance;
  logic              in_fire;

  assign advance   = ~out_tvalid | out_tready;
  assign in_tready = ~in_v_r | advance;
  assign in_fire   = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte_r <= in_tdata;
      in_err_r  <= in_tuser;
    end
  end

  // packet state
  byte_pos_t            pos_r, pos_nxt;
  logic [BYTE_W-1:0]    hdr_r, hdr_nxt;
  logic [BYTE_W-1:0]    xb_r, xb_nxt;
  logic [CW-1:0]        cx_r, cx_nxt;
  logic [CW-1:0]        cy_r, cy_nxt;
  logic                 left_r, left_nxt;
  logic                 right_r, right_nxt;

  logic                 work;
  logic                 emit;
  logic                 dropped;
  logic signed [MOVE_X_W-1:0] dx;
  logic signed [MOVE_Y_W-1:0] dy;
  logic [CW-1:0]        cx_clamp, cy_clamp;

  assign work    = in_v_r & advance & ~in_err_r;
  assign dropped = hdr_r[HDR_X_OVF] | hdr_r[HDR_Y_OVF];
  assign dx      = $signed({hdr_r[HDR_X_SIGN], xb_r});
  assign dy      = -$signed({hdr_r[HDR_Y_SIGN], hdr_r[HDR_Y_SIGN], in_byte_r});

  ps2mct_axis_clamp #(.CW(CW)) u_clamp_x (
    .pos     (cx_r),
    .delta   ({dx[MOVE_X_W-1], dx}),
    .res     (h_res_r),
    .margin  (margin_r),
    .pos_new (cx_clamp)
  );

  ps2mct_axis_clamp #(.CW(CW)) u_clamp_y (
    .pos     (cy_r),
    .delta   (dy),
    .res     (v_res_r),
    .margin  (margin_r),
    .pos_new (cy_clamp)
  );

  always_comb begin
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    xb_nxt    = xb_r;
    cx_nxt    = cx_r;
    cy_nxt    = cy_r;
    left_nxt  = left_r;
    right_nxt = right_r;
    emit      = 1'b0;
    if (work) begin
      case (pos_r)
        ST_WAIT_HDR: begin
          if (in_byte_r[HDR_SYNC]) begin
            hdr_nxt = in_byte_r;
            pos_nxt = ST_GOT_HDR;
          end
        end
        ST_GOT_HDR: begin
          xb_nxt  = in_byte_r;
          pos_nxt = ST_GOT_X;
        end
        ST_GOT_X: begin
          emit    = 1'b1;
          pos_nxt = ST_WAIT_HDR;
          if (!dropped) begin
            left_nxt  = hdr_r[HDR_LEFT];
            right_nxt = hdr_r[HDR_RIGHT];
            cx_nxt    = cx_clamp;
            cy_nxt    = cy_clamp;
          end
        end
        default: pos_nxt = ST_WAIT_HDR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= ST_WAIT_HDR;
      cx_r    <= POS_X_INIT;
      cy_r    <= POS_Y_INIT;
      left_r  <= 1'b0;
      right_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      cx_r    <= cx_nxt;
      cy_r    <= cy_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    xb_r  <= xb_nxt;
  end

  // result register
  logic                 out_v_r;
  logic [USED_W-1:0]    out_data_r;
  logic                 out_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_drop_r <= dropped;
      out_data_r <= {dropped ? '0 : dy,
                     dropped ? '0 : dx,
                     right_nxt, left_nxt, cy_nxt, cx_nxt};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_W-USED_W){1'b0}}, out_data_r};
  assign out_tuser  = out_drop_r;

endmodule

// ===== rtl/ps2mct_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2mct_checker
// Port-level checks for the PS/2 mouse packet cursor tracker, bound to
// the top level.
// ----------------------------------------------------------------------------
module ps2mct_checker #(
  parameter int CW = ps2mct_pkg::COORD_WIDTH_DEF
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tready,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [ps2mct_pkg::out_data_w(CW)-1:0] out_tdata,
  input logic                                  out_tuser
);
  import ps2mct_pkg::*;

  localparam int MX_LO = 2 * CW + 2;
  localparam int MY_LO = MX_LO + MOVE_X_W;

  // stalled transaction holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // reset leaves no result pending
  assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input only back-pressured while a result waits
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without pending result");

  // skipped packet carries no movement
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[MX_LO+MOVE_X_W-1:MX_LO] == '0 && out_tdata[MY_LO+MOVE_Y_W-1:MY_LO] == '0)
    else $error("dropped packet with nonzero movement");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2mct_checker #(.CW(COORD_WIDTH)) u_ps2mct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the PS/2 mouse packet cursor tracker: bytes go in on the input
// stream, a tracker model in the bench frames packets, moves and clamps the
// cursor under the current screen settings, and every cursor report out of
// the block is compared field by field with the oldest predicted report.
// Runs directed packets, clamp and register extremes, then random traffic
// with error bytes and noise under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import ps2mct_pkg::*;

  localparam int COORD_W     = COORD_WIDTH_DEF;
  localparam int COORD_MAX   = (1 << COORD_W) - 1;
  localparam int OUT_W       = out_data_w(COORD_W);
  localparam int PAD_W       = OUT_W - (2 * COORD_W + 2 + MOVE_X_W + MOVE_Y_W);
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE      = 4;

  // cursor report as carried on out_tdata, msb first
  typedef struct packed {
    logic [PAD_W-1:0]    pad;
    logic [MOVE_Y_W-1:0] move_y;
    logic [MOVE_X_W-1:0] move_x;
    logic                right_btn;
    logic                left_btn;
    logic [COORD_W-1:0]  cur_y;
    logic [COORD_W-1:0]  cur_x;
  } cursor_word_t;

  typedef struct {
    cursor_word_t word;
    logic         dropped;
  } cursor_report_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  out_tuser;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  int unsigned sender_idle_pct = 0;
  int unsigned sink_stall_pct  = 0;
  int unsigned err_count       = 0;
  int unsigned cycle_count     = 0;

  cursor_report_t pending_reports[$];

  // tracker model state
  logic [REG_W-1:0]   scr_width  = H_RES_RST;
  logic [REG_W-1:0]   scr_height = V_RES_RST;
  logic [REG_W-1:0]   scr_margin = MARGIN_RST;
  logic               trk_framed = 1'b0;
  byte_pos_t          trk_phase  = ST_WAIT_HDR;
  logic [BYTE_W-1:0]  trk_header = '0;
  logic [BYTE_W-1:0]  trk_xbyte  = '0;
  logic [COORD_W-1:0] trk_x      = COORD_W'(POS_X_RST);
  logic [COORD_W-1:0] trk_y      = COORD_W'(POS_Y_RST);
  logic               trk_left   = 1'b0;
  logic               trk_right  = 1'b0;

  ps2_mouse_packet_cursor_tracker #(
    .COORD_WIDTH(COORD_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("ps2_mouse_packet_cursor_tracker test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  task automatic report_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_error($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  function automatic logic [COORD_W-1:0] clamp_axis(input logic [COORD_W-1:0] pos,
                                                     input int delta,
                                                     input logic [REG_W-1:0] span);
    int limit;
    int target;
    limit  = int'(span) - int'(scr_margin);
    target = int'(pos) + delta;
    if (limit < 0) limit = 0;
    if (limit > COORD_MAX) limit = COORD_MAX;
    if (target >= limit) return COORD_W'(limit);
    if (target < 0) return '0;
    return COORD_W'(target);
  endfunction

  // advances the tracker model by one accepted byte
  task automatic track_rx_byte(input logic [BYTE_W-1:0] b, input logic err);
    cursor_report_t rpt;
    int dx;
    int dy;
    if (err) return;
    if (!trk_framed) begin
      if (!b[HDR_SYNC]) return;
      trk_framed = 1'b1;
      trk_phase  = ST_WAIT_HDR;
    end
    if (trk_phase == ST_WAIT_HDR) begin
      trk_header = b;
      trk_phase  = ST_GOT_HDR;
      return;
    end
    if (trk_phase == ST_GOT_HDR) begin
      trk_xbyte = b;
      trk_phase = ST_GOT_X;
      return;
    end
    trk_phase   = ST_WAIT_HDR;
    trk_framed  = 1'b0;
    dx          = 0;
    dy          = 0;
    rpt.dropped = trk_header[HDR_X_OVF] | trk_header[HDR_Y_OVF];
    if (!rpt.dropped) begin
      trk_left  = trk_header[HDR_LEFT];
      trk_right = trk_header[HDR_RIGHT];
      dx = trk_header[HDR_X_SIGN] ? int'(trk_xbyte) - 256 : int'(trk_xbyte);
      dy = trk_header[HDR_Y_SIGN] ? 256 - int'(b) : -int'(b);
      trk_x = clamp_axis(trk_x, dx, scr_width);
      trk_y = clamp_axis(trk_y, dy, scr_height);
    end
    rpt.word.pad       = '0;
    rpt.word.cur_x     = trk_x;
    rpt.word.cur_y     = trk_y;
    rpt.word.left_btn  = trk_left;
    rpt.word.right_btn = trk_right;
    rpt.word.move_x    = MOVE_X_W'(dx);
    rpt.word.move_y    = MOVE_Y_W'(dy);
    pending_reports.push_back(rpt);
  endtask

  // one byte transaction on the input stream
  task automatic send_rx_byte(input logic [BYTE_W-1:0] value, input logic err);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= err;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    track_rx_byte(value, err);
  endtask

  task automatic send_packet(input logic [BYTE_W-1:0] hdr, input logic [BYTE_W-1:0] xb,
                             input logic [BYTE_W-1:0] yb);
    send_rx_byte(hdr, 1'b0);
    send_rx_byte(xb, 1'b0);
    send_rx_byte(yb, 1'b0);
  endtask

  // holds the sender until every cursor report is back and the block is quiet
  task automatic drain_reports();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [REG_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'({idx, 2'b00});
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_H_RES:  scr_width  = value;
      REG_V_RES:  scr_height = value;
      REG_MARGIN: scr_margin = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_screen(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h,
                            input logic [REG_W-1:0] m);
    drain_reports();
    cfg_write(REG_H_RES, w);
    cfg_write(REG_V_RES, h);
    cfg_write(REG_MARGIN, m);
  endtask

  // packet byte, sometimes preceded by a corrupted byte the block must skip
  task automatic send_packet_byte(input logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 99) < 8)
      send_rx_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
    send_rx_byte(b, 1'b0);
  endtask

  task automatic send_random_packet();
    logic [BYTE_W-1:0] hdr;
    logic [BYTE_W-1:0] junk;
    hdr = BYTE_W'($urandom_range(0, 255));
    hdr[HDR_SYNC] = 1'b1;
    if ($urandom_range(0, 99) < 85) begin
      hdr[HDR_X_OVF] = 1'b0;
      hdr[HDR_Y_OVF] = 1'b0;
    end
    if ($urandom_range(0, 99) < 10) begin
      junk = BYTE_W'($urandom_range(0, 255));
      junk[HDR_SYNC] = 1'b0;
      send_rx_byte(junk, 1'b0);
    end
    send_packet_byte(hdr);
    send_packet_byte(BYTE_W'($urandom_range(0, 255)));
    send_packet_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  always @(posedge clk) begin : report_monitor
    cursor_word_t   got;
    cursor_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = cursor_word_t'(out_tdata);
      if (pending_reports.size() == 0) begin
        report_error("cursor report with nothing pending");
      end else begin
        want = pending_reports.pop_front();
        check_field("cursor_x", int'(got.cur_x), int'(want.word.cur_x));
        check_field("cursor_y", int'(got.cur_y), int'(want.word.cur_y));
        check_field("left_pressed", int'(got.left_btn), int'(want.word.left_btn));
        check_field("right_pressed", int'(got.right_btn), int'(want.word.right_btn));
        check_field("move_x", int'($signed(got.move_x)), int'($signed(want.word.move_x)));
        check_field("move_y", int'($signed(got.move_y)), int'($signed(want.word.move_y)));
        check_field("packet_dropped", int'(out_tuser), int'(want.dropped));
      end
    end
  end

  // framing, buttons, delta extremes and dropped packets at reset settings
  task automatic test_directed_packets();
    sender_idle_pct = 0;
    sink_stall_pct  = 0;
    send_rx_byte(8'h08, 1'b1);
    send_rx_byte(8'hF7, 1'b0);
    send_packet(8'h0B, 8'hFF, 8'h00);
    send_packet(8'h38, 8'h00, 8'h00);
    send_packet(8'h4F, 8'h12, 8'h34);
    send_rx_byte(8'h88, 1'b0);
    send_rx_byte(8'hFF, 1'b1);
    send_rx_byte(8'h00, 1'b0);
    send_rx_byte(8'h08, 1'b0);
    send_packet(8'h08, 8'h01, 8'hFF);
    send_packet(8'h09, 8'hF7, 8'h80);
  endtask

  // register extremes, clamping at both edges and a margin past the screen
  task automatic test_clamp_extremes();
    set_screen(12'd4095, 12'd4095, 12'd0);
    repeat (18) send_packet(8'h28, 8'hFF, 8'h00);
    repeat (4) send_random_packet();
    repeat (18) send_packet(8'h18, 8'h00, 8'hFF);
    set_screen(12'd1, 12'd1, 12'd0);
    repeat (8) send_random_packet();
    set_screen(12'd100, 12'd50, 12'd4095);
    repeat (6) send_random_packet();
    drain_reports();
    cfg_write(REG_NONE, 12'hFFF);
    set_screen(12'd4095, 12'd600, 12'd4000);
    repeat (6) send_random_packet();
  endtask

  task automatic test_random_traffic();
    int unsigned idle_mix[4]  = '{0, 55, 0, 24};
    int unsigned stall_mix[4] = '{0, 0, 55, 24};
    for (int ph = 0; ph < 4; ph++) begin
      set_screen(REG_W'($urandom_range(200, 4095)), REG_W'($urandom_range(200, 4095)),
                 REG_W'($urandom_range(0, 150)));
      sender_idle_pct = idle_mix[ph];
      sink_stall_pct  = stall_mix[ph];
      for (int n = 0; n < 18; n++) begin
        if (n == 9) drain_reports();
        send_random_packet();
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_packets();
    test_clamp_extremes();
    test_random_traffic();
    drain_reports();
    repeat (10) @(posedge clk);
    if (err_count == 0 && pending_reports.size() == 0) begin
      $display("ps2_mouse_packet_cursor_tracker test passed");
    end else begin
      $display("ps2_mouse_packet_cursor_tracker test failed");
    end
    $finish;
  end

endmodule
